@@ sv/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, cell codes, item kinds and controller/datapath links.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int COPY_N  = (ROWS - 1) * COLUMNS;   // cells moved by a scroll

	localparam int ADDR_W = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + 1);        // cursor may touch CELLS briefly
	localparam int COL_W  = $clog2(COLUMNS);

	// fixed field widths of the item and result
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int RADDR_W  = 11;
	localparam int CELL_W   = 16;
	localparam int CURSOR_W = 11;
	localparam int KIND_W   = 2;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE      = 8'h0A;
	localparam logic [CHAR_W-1:0]  SPACE_CODE        = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_BLANK_COLOR = 8'h0F;

	localparam logic REG_BLANK_COLOR = 1'b0;   // register index of blank_color

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;         // capture the accepted item
		logic clear_start;  // start a clear: cursor home, fill with blank color
		logic put;          // character / newline step
		logic copy_step;    // one cell of the scroll copy
		logic fill_step;    // one cell of a fill sweep
		logic result_load;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic scroll;       // put step runs past the last cell
		logic copy_last;    // sweep index at last copied cell
		logic fill_last;    // sweep index at last cell
	} status_t;

endpackage
`default_nettype wire

@@ sv/text_console_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine over an 80x25 cell store
// Puts characters at a cursor, handles newline and scroll, clears and reads.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                  contents
//  s_axis    in    tvalid/tready              tuser: kind; tdata: char, color, addr
//  m_axis    out   tvalid/tready              tdata: cell_data, cursor, scrolled
//  apb       in    psel/penable/pwrite/pready blank_color at byte address 0
//
// Steps: put or newline and read go accept, work, result; an unused kind goes accept, result.
// A scroll adds a row copy, a drain step and a bottom-row fill on the single RAM write port;
// a clear fills every cell, one cell per cycle.
// After reset a clearing pass over every cell loads blanks; items wait,
// configuration writes are taken. A result waits in the output register; the
// next item is taken meanwhile and only its own result load stalls on it.
//
module text_console_writer (
	input  wire         clk,
	input  wire         arst_n,
	// item input
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [7:0] char_code, [15:8] color,
	                                    // [26:16] read_address, [31:27] zero
	input  wire  [1:0]  s_axis_tuser,   // [1:0] kind
	// result output
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] cell_data, [26:16] cursor,
	                                    // [27] scrolled, [31:28] zero
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tcw_pkg::cmd_t    cmd;
	tcw_pkg::status_t status;

	logic [tcw_pkg::COLOR_W-1:0]  blank_color_q;
	logic [tcw_pkg::CELL_W-1:0]   res_cell;
	logic [tcw_pkg::CURSOR_W-1:0] res_cursor;
	logic                         res_scrolled;
	logic                         reg_sel;

	// register file: one register, index taken from paddr[2]
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == tcw_pkg::REG_BLANK_COLOR);
	assign prdata  = reg_sel ? {24'd0, blank_color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_color_q <= tcw_pkg::RESET_BLANK_COLOR;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			blank_color_q <= pwdata[tcw_pkg::COLOR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	tcw_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_kind      (s_axis_tuser),
		.in_char      (s_axis_tdata[7:0]),
		.in_color     (s_axis_tdata[15:8]),
		.in_raddr     (s_axis_tdata[26:16]),
		.blank_color  (blank_color_q),
		.res_cell     (res_cell),
		.res_cursor   (res_cursor),
		.res_scrolled (res_scrolled)
	);

	assign m_axis_tdata = {4'd0, res_scrolled, res_cursor, res_cell};

	// reported cursor always lies on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[26:16]) < tcw_pkg::CELLS))
		else $error("cursor beyond last cell");

	// a scroll leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[27]) |->
			(32'(m_axis_tdata[26:16]) == tcw_pkg::COPY_N))
		else $error("scroll with cursor off the bottom row");

	// a scrolling put never also returns cell data
	a_scroll_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[27]) |-> (m_axis_tdata[15:0] == 16'd0))
		else $error("cell data on a scrolling item");

	// a put command is always followed by a copy or a result stage
	a_put_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> (cmd.copy_step || cmd.result_load || m_axis_tvalid))
		else $error("put step not followed by scroll or result");

endmodule
`default_nettype wire

@@ sv/tcw_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/tcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer of the text console writer
// Steps each item through put, read, scroll and fill sweeps.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	input  wire [tcw_pkg::KIND_W-1:0]   in_kind,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire                         out_ready,
	input  wire tcw_pkg::status_t       status,
	output tcw_pkg::cmd_t               cmd
);

	tcw_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic accept;
	logic slot_free;

	assign accept    = in_valid && (state_q == tcw_pkg::ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (status.fill_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					case (tcw_pkg::kind_t'(in_kind))
						tcw_pkg::KIND_PUT:   state_d = tcw_pkg::ST_PUT;
						tcw_pkg::KIND_CLEAR: state_d = tcw_pkg::ST_FILL;
						tcw_pkg::KIND_READ:  state_d = tcw_pkg::ST_READ;
						default:             state_d = tcw_pkg::ST_DONE;
					endcase
				end
			end
			tcw_pkg::ST_PUT:   state_d = status.scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
			tcw_pkg::ST_READ:  state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_COPY: begin
				if (status.copy_last) state_d = tcw_pkg::ST_DRAIN;
			end
			tcw_pkg::ST_DRAIN: state_d = tcw_pkg::ST_FILL;
			tcw_pkg::ST_FILL: begin
				if (status.fill_last) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				if (slot_free) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			tcw_pkg::ST_INIT:  cmd.fill_step = 1'b1;
			tcw_pkg::ST_IDLE: begin
				cmd.load        = accept;
				cmd.clear_start = accept &&
					(tcw_pkg::kind_t'(in_kind) == tcw_pkg::KIND_CLEAR);
			end
			tcw_pkg::ST_PUT:   cmd.put = 1'b1;
			tcw_pkg::ST_COPY:  cmd.copy_step = 1'b1;
			tcw_pkg::ST_FILL:  cmd.fill_step = 1'b1;
			tcw_pkg::ST_DONE:  cmd.result_load = slot_free;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == tcw_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/tcw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, sweep counter, screen store and result register
// Executes the sequencer's commands on the cell store.
// ----------------------------------------------------------------------------
module tcw_datapath (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire tcw_pkg::cmd_t            cmd,
	output tcw_pkg::status_t              status,
	input  wire [tcw_pkg::KIND_W-1:0]     in_kind,
	input  wire [tcw_pkg::CHAR_W-1:0]     in_char,
	input  wire [tcw_pkg::COLOR_W-1:0]    in_color,
	input  wire [tcw_pkg::RADDR_W-1:0]    in_raddr,
	input  wire [tcw_pkg::COLOR_W-1:0]    blank_color,
	output logic [tcw_pkg::CELL_W-1:0]    res_cell,
	output logic [tcw_pkg::CURSOR_W-1:0]  res_cursor,
	output logic                          res_scrolled
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::CUR_W;
	localparam int LW = tcw_pkg::COL_W;

	logic [tcw_pkg::KIND_W-1:0]  kind_q;
	logic [tcw_pkg::CHAR_W-1:0]  char_q;
	logic [tcw_pkg::COLOR_W-1:0] color_q;
	logic [tcw_pkg::RADDR_W-1:0] raddr_q;

	logic [CW-1:0]               cursor_q;
	logic [LW-1:0]               col_q;
	logic [AW-1:0]               idx_q;
	logic [tcw_pkg::CELL_W-1:0]  fill_q;
	logic                        scrolled_q;

	logic                        copy_wr_s1;
	logic [AW-1:0]               copy_waddr_s1;

	logic                        newline;
	logic [CW-1:0]               cursor_adv;
	logic [LW-1:0]               col_adv;
	logic                        scroll;
	logic                        read_hit;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	assign newline = (char_q == tcw_pkg::NEWLINE_CODE);

	always_comb begin
		if (newline) begin
			cursor_adv = CW'(cursor_q - CW'(col_q) + CW'(tcw_pkg::COLUMNS));
			col_adv    = '0;
		end else begin
			cursor_adv = CW'(cursor_q + 1'b1);
			col_adv    = (col_q == LW'(tcw_pkg::COLUMNS - 1)) ? '0 : LW'(col_q + 1'b1);
		end
	end

	assign scroll   = (cursor_adv >= CW'(tcw_pkg::CELLS));
	assign read_hit = (kind_q == tcw_pkg::KIND_READ) && (32'(raddr_q) < tcw_pkg::CELLS);

	assign status.scroll    = scroll;
	assign status.copy_last = (idx_q == AW'(tcw_pkg::COPY_N - 1));
	assign status.fill_last = (idx_q == AW'(tcw_pkg::CELLS - 1));

	// write port: pending copy write, then fill sweep, then character put
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = fill_q;
		if (copy_wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_waddr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.fill_step) begin
			ram_we = 1'b1;
		end else if (cmd.put && !newline && (cursor_q < CW'(tcw_pkg::CELLS))) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(cursor_q);
			ram_wdata = {color_q, char_q};
		end
	end

	assign ram_raddr = cmd.copy_step ? AW'(idx_q + AW'(tcw_pkg::COLUMNS)) : AW'(raddr_q);

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			char_q  <= in_char;
			color_q <= in_color;
			raddr_q <= in_raddr;
		end
		copy_waddr_s1 <= idx_q;
		if (cmd.result_load) begin
			res_cell     <= read_hit ? ram_rdata : '0;
			res_cursor   <= tcw_pkg::CURSOR_W'(cursor_q);
			res_scrolled <= scrolled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			col_q      <= '0;
			idx_q      <= '0;
			fill_q     <= {tcw_pkg::RESET_BLANK_COLOR, tcw_pkg::SPACE_CODE};
			scrolled_q <= 1'b0;
			copy_wr_s1 <= 1'b0;
		end else begin
			copy_wr_s1 <= cmd.copy_step;
			if (cmd.load) begin
				scrolled_q <= 1'b0;
			end
			if (cmd.clear_start) begin
				cursor_q <= '0;
				col_q    <= '0;
				idx_q    <= '0;
				fill_q   <= {blank_color, tcw_pkg::SPACE_CODE};
			end
			if (cmd.put) begin
				if (scroll) begin
					cursor_q   <= CW'(tcw_pkg::COPY_N);
					col_q      <= '0;
					idx_q      <= '0;
					fill_q     <= {color_q, tcw_pkg::SPACE_CODE};
					scrolled_q <= 1'b1;
				end else begin
					cursor_q <= cursor_adv;
					col_q    <= col_adv;
				end
			end
			// copy ends with idx at the bottom row, where the fill takes over
			if (cmd.copy_step || cmd.fill_step) begin
				idx_q <= (cmd.fill_step && status.fill_last) ? '0 : AW'(idx_q + 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

@@ test/text_console_writer_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_chk: result checker for the text console writer
// Tracks screen cells, cursor and blank color from accepted items and APB
// writes, predicts one result per item and compares it field by field.
// ----------------------------------------------------------------------------
module text_console_writer_chk
	import tcw_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [7:0] char_code, [15:8] color,
	                                    // [26:16] read_address, [31:27] zero
	input  wire  [1:0]  s_axis_tuser,   // [1:0] kind
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [31:0] m_axis_tdata,   // [15:0] cell_data, [26:16] cursor,
	                                    // [27] scrolled, [31:28] zero
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	output int          errors,
	output int          pending
);

	// first member lands in the top bits, so cell_data sits at [15:0]
	typedef struct packed {
		logic                scrolled;
		logic [CURSOR_W-1:0] cursor;
		logic [CELL_W-1:0]   cell_data;
	} console_result_t;

	localparam logic [2:0] BLANK_COLOR_ADDR = 3'(4 * int'(REG_BLANK_COLOR));

	logic [CELL_W-1:0]  screen [CELLS];
	int unsigned        cursor_pos;
	logic [COLOR_W-1:0] blank_color;
	console_result_t    expected_results [$];
	console_result_t    got_result;
	console_result_t    want_result;

	function automatic logic [CELL_W-1:0] blank_cell(input logic [COLOR_W-1:0] color);
		return {color, SPACE_CODE};
	endfunction

	// one item against the shadow screen; returns the result it must produce
	function automatic console_result_t console_step(input logic [KIND_W-1:0] kind,
			input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] color,
			input logic [RADDR_W-1:0] addr);
		console_result_t res;
		res = '0;
		case (kind)
			KIND_PUT: begin
				if (ch == NEWLINE_CODE) begin
					cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
				end else begin
					if (cursor_pos < CELLS)
						screen[cursor_pos] = {color, ch};
					cursor_pos++;
				end
				// ran off the end: shift rows up, fill bottom row in item color
				if (cursor_pos >= CELLS) begin
					for (int i = 0; i < COPY_N; i++)
						screen[i] = screen[i + COLUMNS];
					for (int i = COPY_N; i < CELLS; i++)
						screen[i] = blank_cell(color);
					cursor_pos   = COPY_N;
					res.scrolled = 1'b1;
				end
			end
			KIND_CLEAR: begin
				foreach (screen[i])
					screen[i] = blank_cell(blank_color);
				cursor_pos = 0;
			end
			KIND_READ: begin
				if (addr < CELLS)
					res.cell_data = screen[addr];
			end
			default: ;   // unused kind: no action
		endcase
		res.cursor = CURSOR_W'(cursor_pos);
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (screen[i])
				screen[i] = blank_cell(RESET_BLANK_COLOR);
			cursor_pos  = 0;
			blank_color = RESET_BLANK_COLOR;
			expected_results.delete();
			errors      = 0;
			pending     <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == BLANK_COLOR_ADDR)
				blank_color = pwdata[COLOR_W-1:0];

			if (m_axis_tvalid && m_axis_tready) begin
				got_result = console_result_t'(m_axis_tdata[27:0]);
				if (expected_results.size() == 0) begin
					$error("result with no item pending: tdata 'h%0h", m_axis_tdata);
					errors++;
				end else begin
					want_result = expected_results.pop_front();
					check_field("cell_data", want_result.cell_data, got_result.cell_data);
					check_field("cursor", want_result.cursor, got_result.cursor);
					check_field("scrolled", want_result.scrolled, got_result.scrolled);
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(console_step(s_axis_tuser,
					s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[26:16]));

			pending <= expected_results.size();
		end
	end

endmodule
`default_nettype wire

@@ test/text_console_writer_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_tb: stimulus and verdict for the text console writer
// Drives console items (puts, newlines, clears, cell reads) in bursts against
// a stalling result sink, sweeps the blank color over several settings and
// leaves the checking to text_console_writer_chk.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int CYCLE_LIMIT  = 10_000_000;  // hard-stop bound, far above the run's worst case
	localparam int PHASE_ITEMS  = 250;
	localparam int SETTLE       = 4;           // cycles after the last result

	localparam logic [KIND_W-1:0] KIND_UNUSED      = 2'd3;
	localparam logic [2:0]        BLANK_COLOR_ADDR = 3'(4 * int'(REG_BLANK_COLOR));
	localparam int                MAX_READ_ADDR    = (1 << RADDR_W) - 1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;

	int mismatch_count;
	int pending_results;
	int items_sent = 0;
	int burst_left = 0;
	int ready_run  = 0;
	int ready_mode = 0;

	always #1 clk = ~clk;

	text_console_writer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	text_console_writer_chk chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.errors        (mismatch_count),
		.pending       (pending_results)
	);

	// Result sink: switches between stall modes after runs of random length so
	// stalls hit results of every kind, including those right after a scroll.
	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_run  <= $urandom_range(20, 200);
		end else begin
			ready_run <= ready_run - 1;
		end
		case (ready_mode)
			0:       m_axis_tready <= 1'b1;                         // no stalls
			1:       m_axis_tready <= 1'($urandom_range(0, 1));
			2:       m_axis_tready <= ($urandom_range(0, 7) == 0);  // heavy back-pressure
			default: m_axis_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Hard stop in case the block hangs or drops a result.
	initial begin
		for (int n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// One item per call. Bursts of random length; a gap of idle cycles
	// (sometimes none) opens each new burst. Returns at the accepting edge.
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
			input logic [COLOR_W-1:0] color, input logic [RADDR_W-1:0] addr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {5'b0, addr, color, ch};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Hold off the sender until every outstanding result has been taken.
	// The extra edge lets the checker count the item accepted just now.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left    = 0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_blank_color(input logic [COLOR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BLANK_COLOR_ADDR;
		pwdata  <= {24'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reads lean toward the bottom rows, where scrolls land, and now and
	// then go past the screen.
	function automatic logic [RADDR_W-1:0] pick_read_address();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return RADDR_W'($urandom_range(0, CELLS - 1));
		if (roll < 75)
			return RADDR_W'($urandom_range(COPY_N - COLUMNS, CELLS - 1));
		if (roll < 90)
			return RADDR_W'($urandom_range(0, 2 * COLUMNS - 1));
		return RADDR_W'($urandom_range(CELLS, MAX_READ_ADDR));
	endfunction

	// A line of text: some characters, a newline, a few cell reads, and now
	// and then a clear or an unused kind. Long lines wrap and, on the bottom
	// row, scroll from the character path; newline runs reach the bottom fast.
	task automatic send_line();
		int                 len;
		int                 roll;
		logic [COLOR_W-1:0] line_color;
		roll       = $urandom_range(0, 99);
		line_color = COLOR_W'($urandom);
		if (roll < 20)
			len = 0;
		else if (roll < 70)
			len = $urandom_range(1, 6);
		else if (roll < 92)
			len = $urandom_range(7, 30);
		else
			len = $urandom_range(60, 100);
		repeat (len)
			send_item(KIND_PUT, CHAR_W'($urandom),
				($urandom_range(0, 7) == 0) ? COLOR_W'($urandom) : line_color,
				RADDR_W'($urandom));
		send_item(KIND_PUT, NEWLINE_CODE, COLOR_W'($urandom), RADDR_W'($urandom));
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 30))
				send_item(KIND_PUT, NEWLINE_CODE, COLOR_W'($urandom), RADDR_W'($urandom));
		repeat ($urandom_range(0, 2))
			send_item(KIND_READ, CHAR_W'($urandom), COLOR_W'($urandom), pick_read_address());
		roll = $urandom_range(0, 99);
		if (roll < 3)
			send_item(KIND_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), RADDR_W'($urandom));
		else if (roll < 7)
			send_item(KIND_UNUSED, CHAR_W'($urandom), COLOR_W'($urandom), RADDR_W'($urandom));
	endtask

	initial begin
		logic [COLOR_W-1:0] phase_colors [4];
		int                 target;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		arst_n        <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, read bounds, unused kind, character
		// extremes, newline, then a clear in the new blank color. The write
		// goes in once every earlier result has come back.
		send_item(KIND_READ, 8'h00, 8'h00, '0);                    // reset blank
		send_item(KIND_READ, 8'hFF, 8'hFF, RADDR_W'(CELLS - 1));
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(CELLS));       // just past the screen
		send_item(KIND_READ, 8'h00, 8'h00, '1);
		send_item(KIND_UNUSED, 8'hFF, 8'hFF, '1);
		send_item(KIND_PUT, 8'h00, 8'h00, '0);                     // char zero is a character
		send_item(KIND_PUT, 8'hFF, 8'hFF, '1);
		send_item(KIND_PUT, NEWLINE_CODE, 8'h5A, '0);
		send_item(KIND_PUT, 8'h41, 8'h1E, '0);
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(0));
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(1));
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(2));
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(COLUMNS));
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(COLUMNS + 1));
		wait_drained();
		write_blank_color(8'hC3);
		send_item(KIND_CLEAR, 8'hFF, 8'hFF, '1);
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(0));
		send_item(KIND_READ, 8'h00, 8'h00, RADDR_W'(CELLS - 1));
		wait_drained();

		// Random phases, one blank color each, extremes included. Every
		// phase opens with a clear and pauses for a full drain at its middle.
		phase_colors = '{8'h00, COLOR_W'($urandom), 8'hFF, RESET_BLANK_COLOR};
		foreach (phase_colors[p]) begin
			write_blank_color(phase_colors[p]);
			send_item(KIND_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), RADDR_W'($urandom));
			for (int half = 0; half < 2; half++) begin
				target = items_sent + PHASE_ITEMS / 2;
				while (items_sent < target)
					send_line();
				wait_drained();
			end
		end

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
